>>> src/cadr_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and per-step constants for the double-rotation CORDIC arc cosine.
// Used by cadr_rot, cordic_arccos_double_rotation and cadr_chk; depends on nothing else.
package cadr_pkg;

	// Fixed-point scale and field widths.
	localparam int ONE_SCALE = 1000000;
	localparam int COS_W = 21;
	localparam int ANG_W = 29;
	localparam int VAL_W = 26;
	localparam int SCALE_W = 20;
	localparam int REC_SHIFT = 26;
	localparam int REC_W = 27;
	localparam int REM_W = 21;
	localparam int PROD_W = VAL_W + SCALE_W;
	localparam int TABLE_LEN = 20;
	localparam int DEF_STEPS = 16;

	// Working vector handed from one rotation to the next.
	typedef struct packed {
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] y;
		logic signed [VAL_W-1:0] t;
		logic signed [ANG_W-1:0] th;
		logic                    sneg;
	} vec_t;

	// Arc tangent of 2^-k in micro-degrees.
	function automatic logic [ANG_W-1:0] stage_angle(input int k);
		logic [ANG_W-1:0] a;
		case (k)
			0: a = ANG_W'(44999895);
			1: a = ANG_W'(26564989);
			2: a = ANG_W'(14036211);
			3: a = ANG_W'(7125000);
			4: a = ANG_W'(3576326);
			5: a = ANG_W'(1789906);
			6: a = ANG_W'(895172);
			7: a = ANG_W'(447613);
			8: a = ANG_W'(223810);
			9: a = ANG_W'(111905);
			10: a = ANG_W'(55953);
			11: a = ANG_W'(27976);
			12: a = ANG_W'(13988);
			13: a = ANG_W'(6994);
			14: a = ANG_W'(3497);
			15: a = ANG_W'(1749);
			16: a = ANG_W'(874);
			17: a = ANG_W'(437);
			18: a = ANG_W'(219);
			19: a = ANG_W'(109);
			default: a = '0;
		endcase
		return a;
	endfunction

	// Rotation factor p of step k: the scale halved k times with truncation.
	function automatic logic [SCALE_W-1:0] stage_p(input int k);
		return SCALE_W'(ONE_SCALE >> k);
	endfunction

	// Target scale term p*p at the decimal scale.
	function automatic logic [SCALE_W-1:0] stage_pp(input int k);
		longint p;
		p = longint'(ONE_SCALE >> k);
		return SCALE_W'((p * p) / ONE_SCALE);
	endfunction

	// Reciprocal multiplier for c / ONE_SCALE, slightly low so the quotient is exact or one short.
	function automatic logic [REC_W-1:0] recip(input logic [SCALE_W-1:0] c);
		longint v;
		v = (longint'(c) << REC_SHIFT) / ONE_SCALE;
		return REC_W'(v);
	endfunction

endpackage

>>> src/cadr_rot.sv
`timescale 1ns / 1ps
// One rotation of a double-rotation CORDIC step, three register stages deep.
// Depends on cadr_pkg for the vector type, widths and per-step constants.
module cadr_rot #(
	parameter int STEP = 0,
	parameter int ROT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  cadr_pkg::vec_t vec_i,
	output logic           vld_o,
	output cadr_pkg::vec_t vec_o
);

	localparam int VW = cadr_pkg::VAL_W;
	localparam int PW = cadr_pkg::PROD_W;
	localparam int HW = cadr_pkg::VAL_W + cadr_pkg::REC_W;
	localparam int RW = cadr_pkg::REM_W;
	localparam int AW = cadr_pkg::ANG_W;

	// Per-lane multipliers: x and y rotate by p, the target scales by p*p in the first rotation only.
	localparam logic [cadr_pkg::SCALE_W-1:0] P_C = cadr_pkg::stage_p(STEP);
	localparam logic [cadr_pkg::SCALE_W-1:0] PP_C = (ROT == 0) ? cadr_pkg::stage_pp(STEP) : '0;
	localparam logic [cadr_pkg::REC_W-1:0] PM_C = cadr_pkg::recip(P_C);
	localparam logic [cadr_pkg::REC_W-1:0] PPM_C = cadr_pkg::recip(PP_C);
	localparam logic [cadr_pkg::SCALE_W-1:0] CMUL [3] = '{P_C, P_C, PP_C};
	localparam logic [cadr_pkg::REC_W-1:0] CREC [3] = '{PM_C, PM_C, PPM_C};
	localparam logic signed [AW-1:0] ANG2_C =
		(ROT == 0) ? AW'(cadr_pkg::stage_angle(STEP) << 1) : '0;
	localparam logic [PW-1:0] ONE_P = PW'(cadr_pkg::ONE_SCALE);
	localparam logic [RW-1:0] ONE_R = RW'(cadr_pkg::ONE_SCALE);

	logic                    sneg_c;
	logic signed [VW-1:0]    val_c [3];
	logic                    neg_c [3];
	logic [VW-1:0]           mag_c [3];
	logic [HW-1:0]           hip_c [3];
	logic [PW-1:0]           full_c [3];

	logic                    vld_s1, vld_s2;
	logic                    sneg_s1, sneg_s2;
	logic signed [AW-1:0]    th_s1, th_s2;
	logic signed [VW-1:0]    val_s1 [3];
	logic signed [VW-1:0]    val_s2 [3];
	logic                    neg_s1 [3];
	logic                    neg_s2 [3];
	logic [VW-1:0]           hi_s1 [3];
	logic [VW-1:0]           hi_s2 [3];
	logic [PW-1:0]           full_s1 [3];
	logic [RW-1:0]           rem_s2 [3];
	logic [VW-1:0]           q_c [3];

	// Direction is fixed at the start of a step and reused by its second rotation.
	assign sneg_c = (ROT == 0) ? ((vec_i.y < 0) ^ (vec_i.t > vec_i.x)) : vec_i.sneg;

	// Magnitudes and the two products of each lane.
	always_comb begin
		val_c[0] = vec_i.x;
		val_c[1] = vec_i.y;
		val_c[2] = vec_i.t;
		for (int l = 0; l < 3; l++) begin
			neg_c[l] = val_c[l][VW-1];
			mag_c[l] = neg_c[l] ? VW'(-val_c[l]) : VW'(val_c[l]);
			hip_c[l] = HW'(mag_c[l]) * HW'(CREC[l]);
			full_c[l] = PW'(mag_c[l]) * PW'(CMUL[l]);
		end
	end

	// Stage 1: estimated quotients and exact products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sneg_s1 <= sneg_c;
			th_s1 <= vec_i.th + (sneg_c ? -ANG2_C : ANG2_C);
			for (int l = 0; l < 3; l++) begin
				val_s1[l] <= val_c[l];
				neg_s1[l] <= neg_c[l];
				hi_s1[l] <= VW'(hip_c[l] >> cadr_pkg::REC_SHIFT);
				full_s1[l] <= full_c[l];
			end
		end
	end

	// Stage 2: remainder of the estimate against the exact product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sneg_s2 <= sneg_s1;
			th_s2 <= th_s1;
			for (int l = 0; l < 3; l++) begin
				val_s2[l] <= val_s1[l];
				neg_s2[l] <= neg_s1[l];
				hi_s2[l] <= hi_s1[l];
				rem_s2[l] <= RW'(full_s1[l] - PW'(hi_s1[l]) * ONE_P);
			end
		end
	end

	// Correct the estimate when the remainder reaches one full scale.
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			q_c[l] = hi_s2[l] + VW'(rem_s2[l] >= ONE_R);
		end
	end

	// Stage 3: cross-coupled update of x and y, scaling of the target.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_o.x <= (neg_s2[1] ^ sneg_s2) ? val_s2[0] + signed'(q_c[1])
				: val_s2[0] - signed'(q_c[1]);
			vec_o.y <= (neg_s2[0] ^ sneg_s2) ? val_s2[1] - signed'(q_c[0])
				: val_s2[1] + signed'(q_c[0]);
			vec_o.t <= neg_s2[2] ? val_s2[2] - signed'(q_c[2]) : val_s2[2] + signed'(q_c[2]);
			vec_o.th <= th_s2;
			vec_o.sneg <= sneg_s2;
		end
	end

endmodule

>>> src/cordic_arccos_double_rotation.sv
`timescale 1ns / 1ps
// Input register, two rotations of three stages each per step, then the output register.
// Throughput: one transfer per cycle while cos_stall is low.
// The output holds one result plus a skid entry; the pipeline freezes only when both are full.
// Reset clears all valid bits and the skid entry; data registers are not reset.
// Top level of the arc cosine pipeline; depends on cadr_pkg and cadr_rot.
module cordic_arccos_double_rotation #(
	parameter int STEPS = cadr_pkg::DEF_STEPS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cos_valid,
	output logic                              cos_stall,
	input  logic signed [cadr_pkg::COS_W-1:0] cosine_in,
	output logic                              angle_valid,
	input  logic                              angle_stall,
	output logic signed [cadr_pkg::ANG_W-1:0] angle_out
);

	localparam int VW = cadr_pkg::VAL_W;
	localparam int NROT = 2 * STEPS;
	localparam logic signed [cadr_pkg::COS_W-1:0] ONE_C = cadr_pkg::COS_W'(cadr_pkg::ONE_SCALE);

	logic           en;
	logic           vld_s0;
	cadr_pkg::vec_t vec_s0;
	logic           vld_c [NROT+1];
	cadr_pkg::vec_t vec_c [NROT+1];
	logic signed [cadr_pkg::COS_W-1:0] clip_c;
	logic           out_vld_q, skid_vld_q;
	logic signed [cadr_pkg::ANG_W-1:0] out_q, skid_q;

	assign en = !skid_vld_q;
	assign cos_stall = skid_vld_q;

	// Clip the cosine to plus or minus one full scale.
	always_comb begin
		clip_c = cosine_in;
		if (cosine_in > ONE_C) begin
			clip_c = ONE_C;
		end else if (cosine_in < -ONE_C) begin
			clip_c = -ONE_C;
		end
	end

	// Input register: unit vector at angle zero with the clipped target.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= cos_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s0.x <= VW'(cadr_pkg::ONE_SCALE);
			vec_s0.y <= '0;
			vec_s0.t <= VW'(clip_c);
			vec_s0.th <= '0;
			vec_s0.sneg <= 1'b0;
		end
	end

	assign vld_c[0] = vld_s0;
	assign vec_c[0] = vec_s0;

	// Chain of rotations, two per step.
	for (genvar i = 0; i < NROT; i++) begin : g_rot
		cadr_rot #(
			.STEP(i / 2),
			.ROT (i % 2)
		) u_rot (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_i (vld_c[i]),
			.vec_i (vec_c[i]),
			.vld_o (vld_c[i+1]),
			.vec_o (vec_c[i+1])
		);
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (!out_vld_q || !angle_stall) begin
				skid_vld_q <= 1'b0;
				out_vld_q <= 1'b1;
			end
		end else if (vld_c[NROT]) begin
			if (!out_vld_q || !angle_stall) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (!angle_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (!out_vld_q || !angle_stall) begin
				out_q <= skid_q;
			end
		end else if (vld_c[NROT]) begin
			if (!out_vld_q || !angle_stall) begin
				out_q <= vec_c[NROT].th;
			end else begin
				skid_q <= vec_c[NROT].th;
			end
		end
	end

	assign angle_valid = out_vld_q;
	assign angle_out = out_q;

endmodule

>>> src/cadr_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the arc cosine pipeline, bound to the top level.
// Depends on cadr_pkg for the field widths.
module cadr_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cos_valid,
	input logic                              cos_stall,
	input logic signed [cadr_pkg::COS_W-1:0] cosine_in,
	input logic                              angle_valid,
	input logic                              angle_stall,
	input logic signed [cadr_pkg::ANG_W-1:0] angle_out
);

	// A stalled result stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && angle_stall |=> angle_valid && $stable(angle_out))
		else $error("stalled result changed");

	// The input side only starts stalling after a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cos_stall) |-> $past(angle_valid && angle_stall))
		else $error("input stalled without a stalled result");

	// A stalled input means a result is waiting at the output.
	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		cos_stall |-> angle_valid)
		else $error("input stalled with no result waiting");

	// Angles stay inside plus or minus 200 degrees.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid |-> (angle_out <= 29'sd200000000) && (angle_out >= -29'sd200000000))
		else $error("angle out of range");

endmodule

bind cordic_arccos_double_rotation cadr_chk u_cadr_chk (.*);
